FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/gbsop_pkg.sv
package gbsop_pkg;

    // Default configuration
    localparam int DEF_MAX_SLOTS = 64;
    localparam int DEF_SIZE_BITS = 32;
    localparam int DEF_STEP_BITS = 16;

    // One buffer record request
    typedef struct packed {
        logic [31:0] buf_bytes;
        logic [15:0] first_use;
        logic [15:0] last_use;
        logic        reuse_flag;
        logic [5:0]  reuse_slot;
        logic [15:0] reuse_last_use;
        logic        final_record;
    } t_in_req;

    // One planned slot result
    typedef struct packed {
        logic [5:0]  slot;
        logic        placed;
        logic [39:0] offset;
        logic [39:0] arena_size;
        logic        last_result;
    } t_out_req;

    // Record store write controls
    typedef struct packed {
        logic we;
        logic we_last;
    } t_mem_ctl;

endpackage

FILE: rtl/gbsop_recmem.sv
module gbsop_recmem
    import gbsop_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int STEP_BITS = DEF_STEP_BITS,
    localparam int SW = $clog2(MAX_SLOTS)
) (
    input  logic                 i_clk,
    input  t_mem_ctl             i_ctl,
    input  logic [SW-1:0]        i_wr_addr,
    input  logic [SIZE_BITS-1:0] i_wr_size,
    input  logic [STEP_BITS-1:0] i_wr_first,
    input  logic [STEP_BITS-1:0] i_wr_last,
    input  logic                 i_wr_linkv,
    input  logic [5:0]           i_wr_link,
    input  logic [SW-1:0]        i_last_addr,
    input  logic [STEP_BITS-1:0] i_last_data,
    input  logic [SW-1:0]        i_rd_addr,
    output logic [SIZE_BITS-1:0] o_rd_size,
    output logic [STEP_BITS-1:0] o_rd_first,
    output logic [STEP_BITS-1:0] o_rd_last,
    output logic                 o_rd_linkv,
    output logic [5:0]           o_rd_link
);

    logic [SIZE_BITS-1:0] r_size_mem  [MAX_SLOTS];
    logic [STEP_BITS-1:0] r_first_mem [MAX_SLOTS];
    logic [STEP_BITS-1:0] r_last_mem  [MAX_SLOTS];
    logic [6:0]           r_link_mem  [MAX_SLOTS];

    // Record write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_size_mem[i_wr_addr]  <= i_wr_size;
            r_first_mem[i_wr_addr] <= i_wr_first;
            r_link_mem[i_wr_addr]  <= {i_wr_linkv, i_wr_link};
        end
        o_rd_size  <= r_size_mem[i_rd_addr];
        o_rd_first <= r_first_mem[i_rd_addr];
        {o_rd_linkv, o_rd_link} <= r_link_mem[i_rd_addr];
    end

    // Last use: written by the load, or patched by a reuse record
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_last) begin
            r_last_mem[i_last_addr] <= i_last_data;
        end else if (i_ctl.we) begin
            r_last_mem[i_wr_addr] <= i_wr_last;
        end
        o_rd_last <= r_last_mem[i_rd_addr];
    end

endmodule

FILE: rtl/gbsop_ctrl.sv
module gbsop_ctrl
    import gbsop_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int STEP_BITS = DEF_STEP_BITS,
    localparam int SW = $clog2(MAX_SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mode,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_req              i_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_req             o_res,
    output t_mem_ctl             o_ctl,
    output logic [SW-1:0]        o_wr_addr,
    output logic [SIZE_BITS-1:0] o_wr_size,
    output logic [STEP_BITS-1:0] o_wr_first,
    output logic [STEP_BITS-1:0] o_wr_last,
    output logic                 o_wr_linkv,
    output logic [5:0]           o_wr_link,
    output logic [SW-1:0]        o_last_addr,
    output logic [STEP_BITS-1:0] o_last_data,
    output logic [SW-1:0]        o_rd_addr,
    input  logic [SIZE_BITS-1:0] i_rd_size,
    input  logic [STEP_BITS-1:0] i_rd_first,
    input  logic [STEP_BITS-1:0] i_rd_last,
    input  logic                 i_rd_linkv,
    input  logic [5:0]           i_rd_link
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int OW = SIZE_BITS + CW;

    typedef enum logic [4:0] {
        S_IDLE, S_FIX,
        S_SEQ_RD, S_SEQ_US,
        S_SEL_RD, S_SEL_US,
        S_COL_RD, S_COL_US,
        S_OUT_RD, S_OUT_US, S_IN_RD, S_IN_US, S_EVAL, S_PLACE,
        S_RS_RD, S_RS_US, S_RS_TG, S_RS_TU, S_EMIT
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    logic [SW-1:0]        r_k;
    logic                 r_final;
    logic [5:0]           r_rslot;
    logic [STEP_BITS-1:0] r_rlast;
    logic [OW-1:0]        r_arena;
    logic [MAX_SLOTS-1:0] r_done;
    logic                 r_found;
    logic [SW-1:0]        r_cur;
    logic [SIZE_BITS-1:0] r_cur_size;
    logic [STEP_BITS-1:0] r_cur_first;
    logic [STEP_BITS-1:0] r_cur_last;
    logic [CW-1:0]        r_nb;
    logic [SW-1:0]        r_a;
    logic [SW-1:0]        r_b;
    logic [OW-1:0]        r_e;
    logic                 r_bad;
    logic                 r_has_next;
    logic [OW-1:0]        r_min_s;
    logic                 r_fit;
    logic [OW-1:0]        r_best_gap;
    logic [OW-1:0]        r_best_e;
    logic [OW-1:0]        r_last_end;
    logic [SW-1:0]        r_t;
    logic                 r_ovalid;
    t_out_req             r_out;

    logic [OW:0]          r_off_mem  [MAX_SLOTS];
    logic [2*OW-1:0]      r_live_mem [MAX_SLOTS];
    logic [OW:0]          r_off_q;
    logic [2*OW-1:0]      r_live_q;

    logic [SIZE_BITS+31:0] size_ext;
    logic [STEP_BITS+15:0] first_ext, last_ext, rlast_ext;
    logic                  cnt_full, reuse_ok, last_k, last_a, last_b;
    logic                  cand, ovl, col_we;
    logic [CW-1:0]         n_nb;
    logic [OW-1:0]         sb, eb, gap, res, res_end;
    logic                  off_we;
    logic [SW-1:0]         off_waddr, off_raddr;
    logic [OW:0]           off_wdata;
    logic                  rs_placed;
    logic [OW-1:0]         rs_off;

    // Clamp a wide byte count to the 40-bit output range
    function automatic logic [39:0] f_sat(input logic [OW-1:0] v);
        logic [OW+39:0] w;
        begin
            w = {40'b0, v};
            if (w > {{OW{1'b0}}, {40{1'b1}}}) return {40{1'b1}};
            return w[39:0];
        end
    endfunction

    // Field extraction
    assign size_ext  = {{SIZE_BITS{1'b0}}, i_req.buf_bytes};
    assign first_ext = {{STEP_BITS{1'b0}}, i_req.first_use};
    assign last_ext  = {{STEP_BITS{1'b0}}, i_req.last_use};
    assign rlast_ext = {{STEP_BITS{1'b0}}, i_req.reuse_last_use};
    assign cnt_full  = (r_cnt == CW'(MAX_SLOTS));
    assign reuse_ok  = i_req.reuse_flag &&
                       ({{CW{1'b0}}, i_req.reuse_slot} < {6'b0, r_cnt});

    // Loop ends
    assign last_k = ((CW'(r_k) + CW'(1)) == r_cnt);
    assign last_a = ((CW'(r_a) + CW'(1)) == r_nb);
    assign last_b = ((CW'(r_b) + CW'(1)) == r_nb);

    // Record store ports
    assign o_ctl.we      = (r_state == S_IDLE) && i_valid && !cnt_full;
    assign o_ctl.we_last = (r_state == S_FIX);
    assign o_wr_addr     = r_cnt[SW-1:0];
    assign o_wr_size     = reuse_ok ? '0 : size_ext[SIZE_BITS-1:0];
    assign o_wr_first    = first_ext[STEP_BITS-1:0];
    assign o_wr_last     = last_ext[STEP_BITS-1:0];
    assign o_wr_linkv    = reuse_ok;
    assign o_wr_link     = i_req.reuse_slot;
    assign o_last_addr   = r_rslot[SW-1:0];
    assign o_last_data   = r_rlast;
    assign o_rd_addr     = r_k;

    // Best-fit datapath: select, overlap, gap
    assign cand = (i_rd_size != '0) && !r_done[r_k] &&
                  (!r_found || (i_rd_size > r_cur_size));
    assign ovl  = (r_cur_first < i_rd_first) ? (r_cur_last >= i_rd_first)
                                             : (i_rd_last >= r_cur_first);
    assign col_we = (r_state == S_COL_US) && r_done[r_k] && ovl;
    assign n_nb   = r_nb + CW'(col_we);
    assign sb     = r_live_q[2*OW-1:OW];
    assign eb     = r_live_q[OW-1:0];
    assign gap    = r_min_s - r_e;
    assign res    = (r_nb == '0) ? '0 : (r_fit ? r_best_e : r_last_end);
    assign res_end = res + OW'(r_cur_size);

    // Slot resolution
    always_comb begin
        rs_placed = 1'b0;
        rs_off    = '0;
        if (r_state == S_RS_TU) begin
            rs_placed = r_off_q[OW];
            rs_off    = r_off_q[OW] ? r_off_q[OW-1:0] : '0;
        end else if (i_rd_size != '0) begin
            rs_placed = 1'b1;
            rs_off    = r_off_q[OW-1:0];
        end
    end

    // Offset store write select
    always_comb begin
        off_we    = 1'b0;
        off_waddr = r_k;
        off_wdata = {1'b1, r_arena};
        case (r_state)
            S_SEQ_US: off_we = (i_rd_size != '0);
            S_PLACE: begin
                off_we    = 1'b1;
                off_waddr = r_cur;
                off_wdata = {1'b1, res};
            end
            S_RS_US: begin
                off_we    = !((i_rd_size == '0) && i_rd_linkv);
                off_wdata = {rs_placed, rs_off};
            end
            S_RS_TU: begin
                off_we    = 1'b1;
                off_wdata = {rs_placed, rs_off};
            end
            default: off_we = 1'b0;
        endcase
    end
    assign off_raddr = (r_state == S_RS_TG) ? r_t : r_k;

    // Offset store
    always_ff @(posedge i_clk) begin
        if (off_we) begin
            r_off_mem[off_waddr] <= off_wdata;
        end
        r_off_q <= r_off_mem[off_raddr];
    end

    // Live block store: {start, end}
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_live_mem[r_nb[SW-1:0]] <= {r_off_q[OW-1:0],
                                         r_off_q[OW-1:0] + OW'(i_rd_size)};
        end
        r_live_q <= r_live_mem[(r_state == S_OUT_RD) ? r_a : r_b];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_rslot <= i_req.reuse_slot;
                        r_rlast <= rlast_ext[STEP_BITS-1:0];
                        r_final <= i_req.final_record;
                        if (!cnt_full) r_cnt <= r_cnt + CW'(1);
                        r_k     <= '0;
                        r_arena <= '0;
                        r_done  <= '0;
                        r_found <= 1'b0;
                        if (!cnt_full && reuse_ok) begin
                            r_state <= S_FIX;
                        end else if (i_req.final_record) begin
                            r_state <= i_mode ? S_SEL_RD : S_SEQ_RD;
                        end
                    end
                end
                S_FIX: begin
                    r_state <= r_final ? (i_mode ? S_SEL_RD : S_SEQ_RD) : S_IDLE;
                end
                S_SEQ_RD: r_state <= S_SEQ_US;
                S_SEQ_US: begin
                    if (i_rd_size != '0) r_arena <= r_arena + OW'(i_rd_size);
                    if (last_k) begin
                        r_k     <= '0;
                        r_state <= S_RS_RD;
                    end else begin
                        r_k     <= r_k + SW'(1);
                        r_state <= S_SEQ_RD;
                    end
                end
                S_SEL_RD: r_state <= S_SEL_US;
                S_SEL_US: begin
                    if (cand) begin
                        r_found     <= 1'b1;
                        r_cur       <= r_k;
                        r_cur_size  <= i_rd_size;
                        r_cur_first <= i_rd_first;
                        r_cur_last  <= i_rd_last;
                    end
                    if (last_k) begin
                        r_k     <= '0;
                        r_nb    <= '0;
                        r_state <= (r_found || cand) ? S_COL_RD : S_RS_RD;
                    end else begin
                        r_k     <= r_k + SW'(1);
                        r_state <= S_SEL_RD;
                    end
                end
                S_COL_RD: r_state <= S_COL_US;
                S_COL_US: begin
                    r_nb <= n_nb;
                    if (last_k) begin
                        r_a     <= '0;
                        r_fit   <= 1'b0;
                        r_state <= (n_nb == '0) ? S_PLACE : S_OUT_RD;
                    end else begin
                        r_k     <= r_k + SW'(1);
                        r_state <= S_COL_RD;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_US;
                S_OUT_US: begin
                    r_e        <= eb;
                    r_bad      <= 1'b0;
                    r_has_next <= 1'b0;
                    r_b        <= '0;
                    r_state    <= S_IN_RD;
                end
                S_IN_RD: r_state <= S_IN_US;
                S_IN_US: begin
                    // a block straddling this end means it is not a merged end
                    if (sb <= r_e && eb > r_e) r_bad <= 1'b1;
                    if (sb > r_e && (!r_has_next || sb < r_min_s)) begin
                        r_min_s    <= sb;
                        r_has_next <= 1'b1;
                    end
                    if (last_b) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_b     <= r_b + SW'(1);
                        r_state <= S_IN_RD;
                    end
                end
                S_EVAL: begin
                    if (!r_bad) begin
                        if (!r_has_next) begin
                            r_last_end <= r_e;
                        end else if (gap >= OW'(r_cur_size) &&
                                     (!r_fit || gap < r_best_gap ||
                                      (gap == r_best_gap && r_e < r_best_e))) begin
                            r_fit      <= 1'b1;
                            r_best_gap <= gap;
                            r_best_e   <= r_e;
                        end
                    end
                    if (last_a) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_a     <= r_a + SW'(1);
                        r_state <= S_OUT_RD;
                    end
                end
                S_PLACE: begin
                    if (res_end > r_arena) r_arena <= res_end;
                    r_done[r_cur] <= 1'b1;
                    r_found       <= 1'b0;
                    r_k           <= '0;
                    r_state       <= S_SEL_RD;
                end
                S_RS_RD: r_state <= S_RS_US;
                S_RS_US, S_RS_TU: begin
                    if (r_state == S_RS_US && i_rd_size == '0 && i_rd_linkv) begin
                        r_t     <= i_rd_link[SW-1:0];
                        r_state <= S_RS_TG;
                    end else begin
                        r_ovalid          <= 1'b1;
                        r_out.slot        <= 6'(r_k);
                        r_out.placed      <= rs_placed;
                        r_out.offset      <= f_sat(rs_off);
                        r_out.arena_size  <= last_k ? f_sat(r_arena) : '0;
                        r_out.last_result <= last_k;
                        r_state           <= S_EMIT;
                    end
                end
                S_RS_TG: r_state <= S_RS_TU;
                S_EMIT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if (last_k) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + SW'(1);
                            r_state <= S_RS_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_res   = r_out;

endmodule

FILE: rtl/greedy_by_size_offset_planner.sv
// Buffer offset planner. Records load into slots at one request per cycle
// while idle (a reuse record goes through S_FIX, which patches the reused
// slot's last use through the single write port of the record store). The
// final record starts a plan, during which the input stalls. Sequential mode
// reads the slots in turn. Planning mode repeats, for each nonzero record, a
// scan for the largest unplaced record, a scan that gathers overlapping
// placed blocks, a best-fit search over those blocks, all through one
// registered read port of the live-block memory, and a place step; a last
// scan finds nothing left. Results then leave one per slot, in slot order,
// each held by any output stall; a reuse record's result takes its offset
// from the reused slot.
module greedy_by_size_offset_planner
    import gbsop_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int STEP_BITS = DEF_STEP_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_res,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata
);

    localparam int SW = $clog2(MAX_SLOTS);

    logic                 r_mode;
    t_mem_ctl             ctl;
    logic [SW-1:0]        wr_addr, last_addr, rd_addr;
    logic [SIZE_BITS-1:0] wr_size, rd_size;
    logic [STEP_BITS-1:0] wr_first, wr_last, last_data, rd_first, rd_last;
    logic                 wr_linkv, rd_linkv;
    logic [5:0]           wr_link, rd_link;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    gbsop_recmem #(
        .MAX_SLOTS(MAX_SLOTS), .SIZE_BITS(SIZE_BITS), .STEP_BITS(STEP_BITS)
    ) u_recmem (
        .i_clk(i_clk), .i_ctl(ctl),
        .i_wr_addr(wr_addr), .i_wr_size(wr_size), .i_wr_first(wr_first),
        .i_wr_last(wr_last), .i_wr_linkv(wr_linkv), .i_wr_link(wr_link),
        .i_last_addr(last_addr), .i_last_data(last_data),
        .i_rd_addr(rd_addr), .o_rd_size(rd_size), .o_rd_first(rd_first),
        .o_rd_last(rd_last), .o_rd_linkv(rd_linkv), .o_rd_link(rd_link)
    );

    gbsop_ctrl #(
        .MAX_SLOTS(MAX_SLOTS), .SIZE_BITS(SIZE_BITS), .STEP_BITS(STEP_BITS)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mode(r_mode),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res),
        .o_ctl(ctl), .o_wr_addr(wr_addr), .o_wr_size(wr_size),
        .o_wr_first(wr_first), .o_wr_last(wr_last), .o_wr_linkv(wr_linkv),
        .o_wr_link(wr_link), .o_last_addr(last_addr), .o_last_data(last_data),
        .o_rd_addr(rd_addr), .i_rd_size(rd_size), .i_rd_first(rd_first),
        .i_rd_last(rd_last), .i_rd_linkv(rd_linkv), .i_rd_link(rd_link)
    );

endmodule

FILE: rtl/gbsop_checker.sv
`include "assert_macros.svh"

module gbsop_checker
    import gbsop_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_stall,
    input t_in_req  i_req,
    input logic     o_valid,
    input logic     i_stall,
    input t_out_req o_res,
    input logic     i_cfg_we,
    input logic     i_cfg_wdata
);

    // A held result keeps its payload
    `AST_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_res))
    // No new requests taken while results drain
    `AST_IMP(a_busy, i_clk, i_rst_n, o_valid, o_stall)
    // Unplaced slots report offset zero
    `AST_IMP(a_unplaced, i_clk, i_rst_n, o_valid && !o_res.placed, o_res.offset == 40'd0)
    // Plan ends after its last result
    `AST_NXT(a_end, i_clk, i_rst_n, o_valid && !i_stall && o_res.last_result, !o_valid)
    // Arena only reported on the last result
    `AST_IMP(a_arena, i_clk, i_rst_n, o_valid && !o_res.last_result,
             o_res.arena_size == 40'd0)

endmodule

bind greedy_by_size_offset_planner gbsop_checker u_gbsop_checker (.*);
